// ===== rtl/core/crbt_pkg.sv =====
// Shared constants, codes, types and a helper function of the chunk receive bitmap tracker.
`default_nettype none

package crbt_pkg;

   // Bitmap storage is organized as words of this many chunk bits.
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned WORD_SHIFT = 5;

   // Default number of chunk bits in the map.
   localparam int unsigned MAP_ENTRIES_DEFAULT = 32768;

   // Chunk sizes and their values minus one for ceiling division.
   localparam int unsigned CHUNK_W = 11;
   localparam logic [CHUNK_W-1:0] CHUNK_NORMAL    = 11'd1440;
   localparam logic [CHUNK_W-1:0] CHUNK_LEGACY    = 11'd1024;
   localparam logic [CHUNK_W-1:0] CHUNK_NORMAL_M1 = 11'd1439;
   localparam logic [CHUNK_W-1:0] CHUNK_LEGACY_M1 = 11'd1023;
   localparam int unsigned CHUNK_LEGACY_SHIFT = 10;

   // Division by 1440 is a shift by 5 followed by division by 45, done as a
   // multiplication by ceil(2^34 / 45). The error stays below one part in 45
   // for every dividend under 2^28, so the quotient is exact.
   localparam int unsigned DIVIDEND_W = 33;
   localparam int unsigned DIV_X_W    = 28;
   localparam int unsigned DIV_M_W    = 29;
   localparam int unsigned PROD_W     = DIV_X_W + DIV_M_W;
   localparam int unsigned DIV_SHIFT  = 34;
   localparam logic [DIV_M_W-1:0] RECIP_45 = 29'd381774871;

   // Chunk indexes and chunk counts fit in this width for any 32-bit size.
   localparam int unsigned QW = 23;

   // Byte offset of a chunk from the base, before it is cut to 32 bits.
   localparam int unsigned DONE_W = 34;

   localparam logic [31:0] RAM_LIMIT_RESET = 32'd33554432;

   // Input commands.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CHUNK  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [1:0] RSP_START_OK  = 2'd0;
   localparam logic [1:0] RSP_TOO_LARGE = 2'd1;
   localparam logic [1:0] RSP_COMPLETE  = 2'd2;
   localparam logic [1:0] RSP_MISSING   = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEGACY_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_LIMIT   = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_QUOT,
      S_MARK,
      S_SCAN,
      S_MULT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                  found;
      logic [WORD_SHIFT-1:0] pos;
   } zero_find_type;

   // Lowest bit that is clear in word and set in mask.
   function automatic zero_find_type first_zero(input logic [WORD_BITS-1:0] word,
                                                input logic [WORD_BITS-1:0] mask);
      logic [WORD_BITS-1:0] cand;
      zero_find_type        res;
      cand      = ~word & mask;
      res.found = |cand;
      res.pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            res.pos = WORD_SHIFT'(b);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crbt_intf.sv =====
// Handshake channel interfaces for requests, responses and register writes.
`default_nettype none

interface crbt_req_if import crbt_pkg::*;;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] address;
   logic [31:0] total_bytes;

   modport source (output valid, output command, output address, output total_bytes,
                   input ready);
   modport sink   (input valid, input command, input address, input total_bytes,
                   output ready);
endinterface

interface crbt_rsp_if import crbt_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [31:0]        missing_address;
   logic [CHUNK_W-1:0] missing_size;

   modport source (output valid, output status, output missing_address,
                   output missing_size, input ready);
   modport sink   (input valid, input status, input missing_address,
                   input missing_size, output ready);
endinterface

interface crbt_csr_if import crbt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crbt_map_ram.sv =====
// Single-port-write, single-port-read bitmap memory with registered read data.
`default_nettype none

module crbt_map_ram import crbt_pkg::*; #(
   parameter int unsigned DEPTH = MAP_ENTRIES_DEFAULT / WORD_BITS,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [WORD_BITS-1:0] wdata,
   input  logic                 re,
   input  logic [AW-1:0]        raddr,
   output logic [WORD_BITS-1:0] rdata
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/crbt_chunk_div.sv =====
// Divider by the chunk size: a shift in legacy mode, a reciprocal multiply otherwise.
`default_nettype none

module crbt_chunk_div import crbt_pkg::*; (
   input  logic                  clock,
   input  logic                  legacy,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic [QW-1:0]         quotient
);

   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [QW-1:0]      shq_ff;
   logic [QW-1:0]      shq_in;
   logic               sel_ff;
   logic [DIV_X_W-1:0] x;

   // Dividing by 1440 is dividing by 32 and then by 45.
   assign x       = dividend[DIVIDEND_W-1:WORD_SHIFT];
   assign prod_in = PROD_W'(x) * PROD_W'(RECIP_45);
   assign shq_in  = dividend[DIVIDEND_W-1:CHUNK_LEGACY_SHIFT];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      shq_ff  <= shq_in;
      sel_ff  <= legacy;
   end

   assign quotient = sel_ff ? shq_ff : prod_ff[DIV_SHIFT +: QW];

endmodule

`default_nettype wire

// ===== rtl/core/chunk_receive_bitmap_tracker.sv =====
// Top level of the chunk receive bitmap tracker: control sequencer and result register.
`default_nettype none

// The tracker keeps one bit per upload chunk in a word-organized memory of
// ceil(MAP_ENTRIES / 32) words and serves one request at a time. A start
// request stores the base and size and passes its status through the S_OUT
// state into the output register; if the size is accepted, the bitmap is then
// cleared one word per cycle, and the next request is taken after that pass.
// The same clearing pass runs after reset before the first request is taken.
// A chunk request passes the divider that turns the address offset into a
// chunk index and then does the read-modify-write of the bitmap word; a chunk
// whose index falls outside the map skips the memory step. A finish request
// passes the divider, a scan of at most ceil(min(count, MAP_ENTRIES) / 32)
// words, where count is the number of chunks in the upload, and a multiply
// that turns the first missing chunk into an address; the scan reads one
// bitmap word per cycle over the single memory read port and stops at the
// word holding the first missing chunk. A new request is taken while a
// finished response still waits in the output register; a second response
// waits until the first one has been transferred. Configuration writes are
// always ready and must only be issued while no request is in progress.
module chunk_receive_bitmap_tracker import crbt_pkg::*; #(
   parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   crbt_req_if.sink     req_ch,
   crbt_rsp_if.source   rsp_ch,
   crbt_csr_if.sink     csr_ch
);

   localparam int unsigned WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned AW    = $clog2(WORDS);
   localparam logic [AW-1:0] WORDS_M1 = AW'(WORDS - 1);
   localparam logic [QW-1:0] MAP_Q    = QW'(MAP_ENTRIES);
   localparam logic [DIVIDEND_W-1:0] LEGACY_LIMIT =
      DIVIDEND_W'(MAP_ENTRIES) << CHUNK_LEGACY_SHIFT;

   // Control and configuration state.
   state_type state_ff, state_in;
   logic      legacy_ff;
   logic [31:0] ram_limit_ff;
   logic [31:0] base_ff, base_in;
   logic [31:0] size_ff, size_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic      clear_pend_ff, clear_pend_in;

   // Per-request working registers.
   logic [1:0]            cmd_ff, cmd_in;
   logic [DIVIDEND_W-1:0] div_in_ff, div_in_in;
   logic [QW-1:0]         count_ff, count_in;
   logic [QW-1:0]         lim_ff, lim_in;
   logic [AW-1:0]         scan_w_ff, scan_w_in;
   logic [AW-1:0]         mark_w_ff, mark_w_in;
   logic [WORD_SHIFT-1:0] bit_ff, bit_in;
   logic [QW-1:0]         miss_idx_ff, miss_idx_in;
   logic [DONE_W-1:0]     done_ff, done_in;
   logic [1:0]            res_status_ff, res_status_in;

   // Output register.
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [CHUNK_W-1:0] rsp_size_ff, rsp_size_in;

   // Memory port.
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   // Shared combinational terms.
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 slot_free;
   logic [CHUNK_W-1:0]   chunk;
   logic [CHUNK_W-1:0]   chunk_m1;
   logic [DIVIDEND_W-1:0] size_limit;
   logic                 too_large;
   logic [QW-1:0]        quot;
   logic                 quot_in_map;
   logic [QW-1:0]        scan_base;
   logic [QW-1:0]        scan_rem;
   logic                 scan_last;
   logic [WORD_BITS-1:0] scan_mask;
   zero_find_type        zf;
   logic [31:0]          left;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign chunk    = legacy_ff ? CHUNK_LEGACY : CHUNK_NORMAL;
   assign chunk_m1 = legacy_ff ? CHUNK_LEGACY_M1 : CHUNK_NORMAL_M1;

   assign size_limit = legacy_ff ? LEGACY_LIMIT : DIVIDEND_W'(ram_limit_ff);
   assign too_large  = DIVIDEND_W'(req_ch.total_bytes) > size_limit;

   assign quot_in_map = quot < MAP_Q;

   // The scan checks only the chunks below the scan limit in each word.
   assign scan_base = QW'(scan_w_ff) << WORD_SHIFT;
   assign scan_rem  = lim_ff - scan_base;
   assign scan_last = scan_rem <= QW'(WORD_BITS);
   assign scan_mask = (scan_rem >= QW'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                    : ~({WORD_BITS{1'b1}} << scan_rem[WORD_SHIFT-1:0]);
   assign zf        = first_zero(ram_rdata, scan_mask);

   // A missing chunk always starts below the upload size, so this never wraps.
   assign left = size_ff - done_ff[31:0];

   crbt_chunk_div u_div (
      .clock    (clock),
      .legacy   (legacy_ff),
      .dividend (div_in_ff),
      .quotient (quot)
   );

   crbt_map_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.missing_address = rsp_addr_ff;
   assign rsp_ch.missing_size    = rsp_size_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ptr_ff == WORDS_M1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.command)
                  CMD_START:  state_in = S_OUT;
                  CMD_CHUNK:  state_in = S_DIV;
                  CMD_FINISH: state_in = S_DIV;
                  CMD_UNUSED: state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            state_in = S_QUOT;
         end
         S_QUOT: begin
            priority if (cmd_ff == CMD_CHUNK) begin
               state_in = quot_in_map ? S_MARK : S_IDLE;
            end else begin
               state_in = (quot == '0) ? S_OUT : S_SCAN;
            end
         end
         S_MARK: begin
            state_in = S_IDLE;
         end
         S_SCAN: begin
            priority if (zf.found) begin
               state_in = S_MULT;
            end else if (scan_last) begin
               state_in = (count_ff == lim_ff) ? S_OUT : S_MULT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_MULT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = clear_pend_ff ? S_CLEAR : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath, memory port and output register controls.
   always_comb begin
      base_in       = base_ff;
      size_in       = size_ff;
      clr_ptr_in    = clr_ptr_ff;
      clear_pend_in = clear_pend_ff;
      cmd_in        = cmd_ff;
      div_in_in     = div_in_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      scan_w_in     = scan_w_ff;
      mark_w_in     = mark_w_ff;
      bit_in        = bit_ff;
      miss_idx_in   = miss_idx_ff;
      done_in       = done_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ptr_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_ptr_ff;
            ram_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + AW'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = req_ch.command;
               unique case (req_ch.command)
                  CMD_START: begin
                     // A rejected start still records base and size.
                     base_in       = req_ch.address;
                     size_in       = req_ch.total_bytes;
                     res_status_in = too_large ? RSP_TOO_LARGE : RSP_START_OK;
                     clear_pend_in = !too_large;
                     clr_ptr_in    = '0;
                  end
                  CMD_CHUNK: begin
                     // The offset wraps at 32 bits before it is divided.
                     div_in_in = {1'b0, req_ch.address - base_ff};
                  end
                  CMD_FINISH: begin
                     div_in_in     = DIVIDEND_W'(size_ff) + DIVIDEND_W'(chunk_m1);
                     clear_pend_in = 1'b0;
                  end
                  CMD_UNUSED: begin
                     cmd_in = cmd_ff;
                  end
               endcase
            end
         end
         S_DIV: begin
            div_in_in = div_in_ff;
         end
         S_QUOT: begin
            priority if (cmd_ff == CMD_CHUNK) begin
               mark_w_in = AW'(quot >> WORD_SHIFT);
               bit_in    = quot[WORD_SHIFT-1:0];
               ram_re    = quot_in_map;
               ram_raddr = AW'(quot >> WORD_SHIFT);
            end else begin
               count_in      = quot;
               lim_in        = quot_in_map ? quot : MAP_Q;
               scan_w_in     = '0;
               res_status_in = RSP_COMPLETE;
               ram_re        = (quot != '0);
               ram_raddr     = '0;
            end
         end
         S_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = mark_w_ff;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_ff);
         end
         S_SCAN: begin
            priority if (zf.found) begin
               miss_idx_in   = scan_base | QW'(zf.pos);
               res_status_in = RSP_MISSING;
            end else if (scan_last) begin
               // Chunks past the end of the map count as missing.
               miss_idx_in   = lim_ff;
               res_status_in = (count_ff == lim_ff) ? RSP_COMPLETE : RSP_MISSING;
            end else begin
               scan_w_in = scan_w_ff + AW'(1);
               ram_re    = 1'b1;
               ram_raddr = scan_w_ff + AW'(1);
            end
         end
         S_MULT: begin
            done_in = DONE_W'(miss_idx_ff) * DONE_W'(chunk);
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == RSP_MISSING) begin
                  rsp_addr_in = base_ff + done_ff[31:0];
                  rsp_size_in = (left < 32'(chunk)) ? left[CHUNK_W-1:0] : chunk;
               end else begin
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end
            end
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ptr_ff    <= '0;
         clear_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         legacy_ff     <= 1'b0;
         ram_limit_ff  <= RAM_LIMIT_RESET;
         base_ff       <= '0;
         size_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         clear_pend_ff <= clear_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         base_ff       <= base_in;
         size_ff       <= size_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               CSR_LEGACY_MODE: legacy_ff    <= csr_ch.data[0];
               CSR_RAM_LIMIT:   ram_limit_ff <= csr_ch.data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      div_in_ff     <= div_in_in;
      count_ff      <= count_in;
      lim_ff        <= lim_in;
      scan_w_ff     <= scan_w_in;
      mark_w_ff     <= mark_w_in;
      bit_ff        <= bit_in;
      miss_idx_ff   <= miss_idx_in;
      done_ff       <= done_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

`ifndef SYNTHESIS
   // A missing-chunk response always names a non-empty chunk no larger than a normal-size chunk.
   a_missing_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == RSP_MISSING) |->
         (rsp_size_ff != '0) && (rsp_size_ff <= CHUNK_NORMAL))
      else $error("missing chunk size out of range");

   // Start and complete responses carry zero address and size.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != RSP_MISSING) |->
         (rsp_addr_ff == '0) && (rsp_size_ff == '0))
      else $error("non-missing response with nonzero fields");

   // Every memory access stays inside the bitmap.
   a_ram_range: assert property (@(posedge clock) disable iff (reset)
      (ram_re |-> ram_raddr <= WORDS_M1) and (ram_we |-> ram_waddr <= WORDS_M1))
      else $error("bitmap access out of range");

   // The scan runs only over a non-empty limit that does not exceed the chunk count.
   a_scan_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (lim_ff != '0) && (lim_ff <= count_ff))
      else $error("scan limit inconsistent with chunk count");
`endif

endmodule

`default_nettype wire
